### sv/lbms_pkg.sv
// Shared types and constants of the LED bar matrix scanner.
// No dependencies; used by the front, back and top-level files.
`default_nettype none

package lbms_pkg;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET_HEIGHT = 2'd1,
        OP_SET_PIXEL  = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] REG_SCAN_PERIOD  = 2'd0;
    localparam logic [1:0] REG_DECAY_PERIOD = 2'd1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CNT_W       = 16;
    localparam int COL_W       = 4;
    localparam int AMT_W       = 4;
    localparam int ROW_OUT_W   = 8;
    localparam int SINK_W      = 16;

    localparam logic [CNT_W-1:0]  CNT_MAX            = 16'hFFFF;
    localparam logic [CNT_W-1:0]  SCAN_PERIOD_RESET  = 16'd1;
    localparam logic [CNT_W-1:0]  DECAY_PERIOD_RESET = 16'd200;
    localparam logic [SINK_W-1:0] BLANK_SINK         = 16'h00FF;

    // Command queue depth between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Classified command: amount is already the saturated height or the row index
    typedef struct packed {
        op_t              op;
        logic             col_hit;
        logic [COL_W-1:0] column;
        logic [AMT_W-1:0] amount;
    } cmd_t;

endpackage

`default_nettype wire

### sv/lbms_front.sv
// Front end of the LED bar matrix scanner: accepts input beats, classifies
// them into commands and buffers them in a short queue. Depends on lbms_pkg.
`default_nettype none

module lbms_front
    import lbms_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int ROW_BITS    = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [1:0]       s_tuser,
    input  wire logic [COL_W-1:0] s_column,
    input  wire logic [AMT_W-1:0] s_amount,
    output logic                  q_valid,
    output cmd_t                  q_cmd,
    input  wire logic             q_pop
);

    cmd_t                 cmd_in;
    logic [AMT_W:0]       amt_ext;
    logic [AMT_W:0]       row_rem;
    logic                 push;

    cmd_t                 q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    // Classify: saturate height, reduce pixel row modulo the row count
    always_comb begin
        amt_ext = {1'b0, s_amount};
        row_rem = amt_ext;
        for (int k = 0; k < 8; k++) begin
            if (row_rem >= (AMT_W+1)'(ROW_BITS)) begin
                row_rem = row_rem - (AMT_W+1)'(ROW_BITS);
            end
        end
        cmd_in.op      = op_t'(s_tuser);
        cmd_in.column  = s_column;
        cmd_in.col_hit = (int'(s_column) < NUM_COLUMNS);
        cmd_in.amount  = s_amount;
        if (op_t'(s_tuser) == OP_SET_HEIGHT) begin
            if (amt_ext > (AMT_W+1)'(ROW_BITS)) begin
                cmd_in.amount = AMT_W'(ROW_BITS);
            end
        end else if (op_t'(s_tuser) == OP_SET_PIXEL) begin
            cmd_in.amount = row_rem[AMT_W-1:0];
        end
    end

    // Queue handshake
    assign s_tready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified beat
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

### sv/lbms_back.sv
// Back end of the LED bar matrix scanner: holds the frame, counters and
// configuration, executes commands and registers scan steps. Depends on lbms_pkg.
`default_nettype none

module lbms_back
    import lbms_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int ROW_BITS    = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [ROW_OUT_W-1:0]        m_row_bits,
    output logic [SINK_W-1:0]           m_sink_mask
);

    localparam int COL_IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int POS_W     = $clog2(NUM_COLUMNS + 1);

    logic [ROW_BITS-1:0]  frame_reg [NUM_COLUMNS];
    logic [ROW_BITS-1:0]  frame_next [NUM_COLUMNS];
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]     decay_cnt_reg, decay_cnt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     scan_period_reg, decay_period_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [ROW_OUT_W-1:0] row_out_reg, row_out_next;
    logic [SINK_W-1:0]    sink_out_reg, sink_out_next;

    logic [CNT_W-1:0]     scan_inc, decay_inc;
    logic                 decay_hit, scan_hit, blank;
    logic [ROW_BITS-1:0]  pattern, col_pat;
    logic [COL_IDX_W-1:0] wr_idx, rd_idx;

    // Pop when the output register is free or draining this cycle
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    assign scan_inc  = (scan_cnt_reg >= CNT_MAX) ? CNT_MAX : scan_cnt_reg + 1'b1;
    assign decay_inc = (decay_cnt_reg >= CNT_MAX) ? CNT_MAX : decay_cnt_reg + 1'b1;
    assign decay_hit = (decay_inc >= decay_period_reg);
    assign scan_hit  = (scan_inc >= scan_period_reg);
    assign blank     = (pos_reg == POS_W'(NUM_COLUMNS));
    assign wr_idx    = COL_IDX_W'(q_cmd.column);
    assign rd_idx    = pos_reg[COL_IDX_W-1:0];

    // Build the stored pattern: thermometer for a height, one-hot for a pixel
    always_comb begin
        for (int i = 0; i < ROW_BITS; i++) begin
            if (q_cmd.op == OP_SET_HEIGHT) begin
                pattern[i] = (int'(q_cmd.amount) > i);
            end else begin
                pattern[i] = (int'(q_cmd.amount) == i);
            end
        end
    end

    // Column seen by a scan step, after this tick's decay
    assign col_pat = decay_hit ? (frame_reg[rd_idx] >> 1) : frame_reg[rd_idx];

    // Execute one command
    always_comb begin
        frame_next     = frame_reg;
        scan_cnt_next  = scan_cnt_reg;
        decay_cnt_next = decay_cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        row_out_next   = row_out_reg;
        sink_out_next  = sink_out_reg;
        if (q_pop) begin
            unique case (q_cmd.op)
                OP_SET_HEIGHT, OP_SET_PIXEL: begin
                    if (q_cmd.col_hit) begin
                        frame_next[wr_idx] = pattern;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NUM_COLUMNS; i++) begin
                        frame_next[i] = '0;
                    end
                end
                OP_TICK: begin
                    scan_cnt_next  = scan_inc;
                    decay_cnt_next = decay_inc;
                    if (decay_hit) begin
                        decay_cnt_next = '0;
                        for (int i = 0; i < NUM_COLUMNS; i++) begin
                            frame_next[i] = frame_reg[i] >> 1;
                        end
                    end
                    if (scan_hit) begin
                        scan_cnt_next  = '0;
                        out_valid_next = 1'b1;
                        if (blank) begin
                            row_out_next  = '0;
                            sink_out_next = BLANK_SINK;
                            pos_next      = '0;
                        end else begin
                            row_out_next  = ROW_OUT_W'(col_pat);
                            sink_out_next = SINK_W'(33'd1 << pos_reg);
                            pos_next      = pos_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COLUMNS; i++) begin
                frame_reg[i] <= '0;
            end
            scan_cnt_reg     <= '0;
            decay_cnt_reg    <= '0;
            pos_reg          <= '0;
            out_valid_reg    <= 1'b0;
            scan_period_reg  <= SCAN_PERIOD_RESET;
            decay_period_reg <= DECAY_PERIOD_RESET;
        end else begin
            frame_reg     <= frame_next;
            scan_cnt_reg  <= scan_cnt_next;
            decay_cnt_reg <= decay_cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            // Configuration writes; other indexes are dropped
            if (cfg_wr_en) begin
                if (cfg_index == REG_SCAN_PERIOD) begin
                    scan_period_reg <= cfg_wr_data;
                end else if (cfg_index == REG_DECAY_PERIOD) begin
                    decay_period_reg <= cfg_wr_data;
                end
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        row_out_reg  <= row_out_next;
        sink_out_reg <= sink_out_next;
    end

    assign m_tvalid    = out_valid_reg;
    assign m_row_bits  = row_out_reg;
    assign m_sink_mask = sink_out_reg;

endmodule

`default_nettype wire

### sv/led_bar_matrix_scanner.sv
// LED bar matrix scanner, top level: joins the command front end and the
// frame back end. Depends on lbms_pkg, lbms_front and lbms_back.
//
// Drives a multiplexed bar display of NUM_COLUMNS columns by ROW_BITS rows.
// Each input beat carries an operation on s_tuser (tick, set height, set
// pixel, clear) with column and amount on s_tdata. Ticks advance a decay
// counter (every column shifts down one row when it reaches decay_period) and
// a scan counter; each time the scan counter reaches scan_period one scan
// beat leaves on m_*: the pattern and a one-hot sink for each column in turn,
// then one blank beat (rows zero, sink 0x00FF). Rate: one input beat per
// cycle while m_tready does not hold the back end; every beat passes the
// two-entry command queue and is executed by the back end. The back end
// holds any queued beat while the single output register is full and
// m_tready is low, and s_tready drops once the queue holds two beats. A
// scan beat passes the queue register, then the output register, before
// it is presented on m_*. Write configuration only while the block is idle.
`default_nettype none

module led_bar_matrix_scanner
    import lbms_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int ROW_BITS    = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration write port
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [3:0] column, [7:4] amount
    input  wire logic [1:0]             s_tuser,   // [1:0] operation
    // Scan step stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [23:0]                 m_tdata    // [7:0] row_bits, [23:8] sink_mask
);

    logic                 q_valid;
    cmd_t                 q_cmd;
    logic                 q_pop;
    logic [ROW_OUT_W-1:0] row_bits;
    logic [SINK_W-1:0]    sink_mask;

    lbms_front #(
        .NUM_COLUMNS(NUM_COLUMNS),
        .ROW_BITS   (ROW_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_column(s_tdata[3:0]),
        .s_amount(s_tdata[7:4]),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    lbms_back #(
        .NUM_COLUMNS(NUM_COLUMNS),
        .ROW_BITS   (ROW_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_row_bits (row_bits),
        .m_sink_mask(sink_mask)
    );

    // Pack the scan beat
    assign m_tdata = {sink_mask, row_bits};

endmodule

`default_nettype wire
